// ----- rtl/rate_weighted_hop_select_core_macros.svh -----
// Assertion macros used by the checker file of the hop select core.
// No dependencies; take in with an include before the module header.
`ifndef RATE_WEIGHTED_HOP_SELECT_CORE_MACROS_SVH
`define RATE_WEIGHTED_HOP_SELECT_CORE_MACROS_SVH

// Same-cycle implication, held off during reset
`define RWHS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define RWHS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rwhs_pkg.sv -----
// Types and constants of the rate weighted hop select core.
// No dependencies; imported by the core and its checker.
package rwhs_pkg;

  localparam int RATE_BITS        = 32;
  localparam int SITE_BITS        = 20;
  localparam int UNIFORM_BITS     = 16;
  localparam int SLOT_BITS        = 6;
  localparam int SHORT_COUNT_BITS = 6;
  localparam int LONG_COUNT_BITS  = 7;
  localparam int CFG_DATA_BITS    = 7;
  localparam int SHORT_TYPES      = 3;

  typedef enum logic [1:0] {
    KIND_WRITE_SHORT = 2'd0,
    KIND_WRITE_LONG  = 2'd1,
    KIND_RECOMPUTE   = 2'd2,
    KIND_SELECT      = 2'd3
  } kind_t;

  localparam logic [1:0] TYPE_ELECTRON = 2'd0;
  localparam logic [1:0] TYPE_TRIPLET  = 2'd2;
  localparam logic [1:0] TYPE_SINGLET  = 2'd3;

  localparam logic REG_SHORT_COUNT = 1'b0;
  localparam logic REG_LONG_COUNT  = 1'b1;

  localparam logic STATUS_FOUND  = 1'b0;
  localparam logic STATUS_FAILED = 1'b1;

  typedef struct packed {
    kind_t                 kind;
    logic [1:0]            carrier_type;
    logic [SLOT_BITS-1:0]  slot;
    logic [RATE_BITS-1:0]  rate;
    logic [SITE_BITS-1:0]  neighbour_site;
    logic [UNIFORM_BITS-1:0] uniform;
  } in_item_t;

  typedef struct packed {
    logic [SITE_BITS-1:0] next_site;
    logic                 status;
  } out_item_t;

endpackage

// ----- rtl/rate_weighted_hop_select_core.sv -----
// Hop select: a write is taken in S_IDLE; a select runs 16 multiply steps in S_MUL, then
// walks the list in S_WALK until the running sum reaches the target or the list runs out;
// a recompute walks the three short lists and the long list. One request at a time. The pace is
// set by the single shared adder, used first for the shift-add scaling of the total and then
// for the running sum, one stored rate per cycle from the one read port of each rate memory.
// Synchronous reset clears counts, totals and out_valid; list memories are undefined.
module rate_weighted_hop_select_core
  import rwhs_pkg::*;
#(
  parameter int MAX_SHORT = 32,
  parameter int MAX_LONG  = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int MAX_LIST = (MAX_SHORT > MAX_LONG) ? MAX_SHORT : MAX_LONG;
  localparam int LEN_MIN  = $clog2(MAX_LIST + 1);
  localparam int IDX_W    = (LEN_MIN > LONG_COUNT_BITS) ? LEN_MIN : LONG_COUNT_BITS;
  localparam int SA_W     = (MAX_SHORT > 1) ? $clog2(MAX_SHORT) : 1;
  localparam int LA_W     = (MAX_LONG > 1) ? $clog2(MAX_LONG) : 1;
  localparam int TOT_W    = RATE_BITS + LEN_MIN;
  localparam int PROD_W   = TOT_W + UNIFORM_BITS;
  localparam int MC_W     = $clog2(UNIFORM_BITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_WALK = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t st;

  logic [SHORT_COUNT_BITS-1:0] short_count;
  logic [LONG_COUNT_BITS-1:0]  long_count;

  logic [1:0]              rtype;
  logic                    recompute;
  logic [UNIFORM_BITS-1:0] uni_sh;
  logic [MC_W-1:0]         mcount;
  logic [PROD_W-1:0]       prod;
  logic [TOT_W-1:0]        sum;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        len;
  logic                    rd_ok;
  logic [TOT_W-1:0]        totals [4];
  logic [SITE_BITS-1:0]    res_site;
  logic                    res_status;

  // list memories
  logic [RATE_BITS-1:0] short_rate_mem [SHORT_TYPES][MAX_SHORT];
  logic [SITE_BITS-1:0] short_site_mem [MAX_SHORT];
  logic [RATE_BITS-1:0] long_rate_mem  [MAX_LONG];
  logic [SITE_BITS-1:0] long_site_mem  [MAX_LONG];

  logic [RATE_BITS-1:0] rd_short_rate;
  logic [RATE_BITS-1:0] rd_long_rate;
  logic [SITE_BITS-1:0] rd_short_site;
  logic [SITE_BITS-1:0] rd_long_site;

  logic                 in_fire;
  logic [IDX_W-1:0]     short_len;
  logic [IDX_W-1:0]     long_len;
  logic [IDX_W-1:0]     slot_ext;
  logic [1:0]           short_rd_type;
  logic [RATE_BITS-1:0] rate_rd;
  logic [SITE_BITS-1:0] site_rd;
  logic [TOT_W-1:0]     total_sel;
  logic [PROD_W-1:0]    add_a;
  logic [PROD_W-1:0]    add_b;
  logic [PROD_W-1:0]    add_y;
  logic [TOT_W-1:0]     cand;
  logic                 hit;
  logic                 issue;

  assign in_ready = (st == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign short_len = (IDX_W'(short_count) < IDX_W'(MAX_SHORT)) ?
                     IDX_W'(short_count) : IDX_W'(MAX_SHORT);
  assign long_len  = (IDX_W'(long_count) < IDX_W'(MAX_LONG)) ?
                     IDX_W'(long_count) : IDX_W'(MAX_LONG);
  assign slot_ext  = IDX_W'(in_data.slot);

  assign short_rd_type = (rtype == TYPE_SINGLET) ? TYPE_ELECTRON : rtype;
  assign rate_rd       = (rtype == TYPE_SINGLET) ? rd_long_rate : rd_short_rate;
  assign site_rd       = (rtype == TYPE_SINGLET) ? rd_long_site : rd_short_site;
  assign total_sel     = totals[rtype];
  assign issue         = (idx < len);

  // shared adder: shift-add scaling step, or running sum step
  always_comb begin
    if (st == S_MUL) begin
      add_a = prod << 1;
      add_b = uni_sh[UNIFORM_BITS-1] ? PROD_W'(total_sel) : '0;
    end else begin
      add_a = PROD_W'(sum);
      add_b = PROD_W'(rate_rd);
    end
  end

  assign add_y = add_a + add_b;
  assign cand  = add_y[TOT_W-1:0];
  // sum >= ceil(prod / 2^U) exactly when sum * 2^U >= prod
  assign hit   = ({cand, {UNIFORM_BITS{1'b0}}} >= prod);

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.kind == KIND_WRITE_SHORT) &&
        (in_data.carrier_type != TYPE_SINGLET) && (slot_ext < short_len)) begin
      short_rate_mem[in_data.carrier_type][slot_ext[SA_W-1:0]] <= in_data.rate;
      short_site_mem[slot_ext[SA_W-1:0]] <= in_data.neighbour_site;
    end
    if (in_fire && (in_data.kind == KIND_WRITE_LONG) && (slot_ext < long_len)) begin
      long_rate_mem[slot_ext[LA_W-1:0]] <= in_data.rate;
      long_site_mem[slot_ext[LA_W-1:0]] <= in_data.neighbour_site;
    end
    rd_short_rate <= short_rate_mem[short_rd_type][idx[SA_W-1:0]];
    rd_short_site <= short_site_mem[idx[SA_W-1:0]];
    rd_long_rate  <= long_rate_mem[idx[LA_W-1:0]];
    rd_long_site  <= long_site_mem[idx[LA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      short_count <= '0;
      long_count  <= '0;
      rtype       <= TYPE_ELECTRON;
      recompute   <= 1'b0;
      mcount      <= '0;
      idx         <= '0;
      rd_ok       <= 1'b0;
      out_valid   <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        totals[k] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SHORT_COUNT: short_count <= cfg_data[SHORT_COUNT_BITS-1:0];
          REG_LONG_COUNT:  long_count  <= cfg_data[LONG_COUNT_BITS-1:0];
          default: ;
        endcase
      end

      // S_OUT owns out_valid in its own cycles
      if (out_valid && out_ready && (st != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (st)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_data.kind)
              KIND_RECOMPUTE: begin
                recompute <= 1'b1;
                rtype     <= TYPE_ELECTRON;
                len       <= short_len;
                idx       <= '0;
                sum       <= '0;
                rd_ok     <= 1'b0;
                st        <= S_WALK;
              end
              KIND_SELECT: begin
                recompute <= 1'b0;
                rtype     <= in_data.carrier_type;
                uni_sh    <= in_data.uniform;
                prod      <= '0;
                mcount    <= MC_W'(UNIFORM_BITS - 1);
                st        <= S_MUL;
              end
              default: ;
            endcase
          end
        end

        S_MUL: begin
          prod   <= add_y;
          uni_sh <= uni_sh << 1;
          mcount <= mcount - 1'b1;
          if (mcount == '0) begin
            len   <= (rtype == TYPE_SINGLET) ? long_len : short_len;
            idx   <= '0;
            sum   <= '0;
            rd_ok <= 1'b0;
            st    <= S_WALK;
          end
        end

        S_WALK: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end
          rd_ok <= issue;
          if (rd_ok) begin
            sum <= cand;
          end
          if (!recompute && rd_ok && hit) begin
            res_site   <= site_rd;
            res_status <= STATUS_FOUND;
            st         <= S_OUT;
          end else if (!rd_ok && !issue) begin
            if (recompute) begin
              totals[rtype] <= sum;
              if (rtype == TYPE_SINGLET) begin
                st <= S_IDLE;
              end else begin
                rtype <= rtype + 2'd1;
                len   <= (rtype == TYPE_TRIPLET) ? long_len : short_len;
                idx   <= '0;
                sum   <= '0;
              end
            end else begin
              // list ran out before the target: empty list or stale total
              res_site   <= '0;
              res_status <= STATUS_FAILED;
              st         <= S_OUT;
            end
          end
        end

        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.next_site <= res_site;
            out_data.status    <= res_status;
            st                 <= S_IDLE;
          end
        end

        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rwhs_checker.sv -----
// Port-level checker for the rate weighted hop select core, with its bind.
// Depends on rwhs_pkg and rate_weighted_hop_select_core_macros.svh.
`include "rate_weighted_hop_select_core_macros.svh"

module rwhs_checker
  import rwhs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result holds
  `RWHS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // a failed search never reports a site
  `RWHS_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && (out_data.status == STATUS_FAILED), out_data.next_site == '0, "failed search with non-zero site")

  // select and recompute requests occupy the block
  `RWHS_ASSERT_NXT(a_long_busy, clk, rst, in_valid && in_ready && (in_data.kind == KIND_SELECT || in_data.kind == KIND_RECOMPUTE), !in_ready, "ready straight after a select or recompute")

  // list writes finish in their own cycle
  `RWHS_ASSERT_NXT(a_write_quick, clk, rst, in_valid && in_ready && (in_data.kind == KIND_WRITE_SHORT || in_data.kind == KIND_WRITE_LONG), in_ready, "not ready after a list write")

  // no result straight out of reset
  `RWHS_ASSERT_IMP(a_reset_clear, clk, rst, $past(rst), !out_valid, "result valid after reset")

endmodule

bind rate_weighted_hop_select_core rwhs_checker u_rwhs_checker (.*);
